### hdl/pcbs_pkg.sv
// shared types, codes and helpers for the path command to bezier segment block
package pcbs_pkg;

	localparam int MaxArgs    = 6;
	localparam int QueueDepth = 2;
	localparam int CoordW     = 32;
	localparam int UnitsW     = 31;
	localparam int KindW      = 3;
	localparam int CntW       = $clog2(MaxArgs + 1);

	localparam logic [KindW-1:0] KindNumber  = 3'd0;
	localparam logic [KindW-1:0] KindMove    = 3'd1;
	localparam logic [KindW-1:0] KindCurve   = 3'd2;
	localparam logic [KindW-1:0] KindSmooth  = 3'd3;
	localparam logic [KindW-1:0] KindLine    = 3'd4;
	localparam logic [KindW-1:0] KindHoriz   = 3'd5;
	localparam logic [KindW-1:0] KindVert    = 3'd6;
	localparam logic [KindW-1:0] KindUnused  = 3'd7;
	localparam logic [KindW-1:0] KindNone    = 3'd0;

	localparam logic RegWidth  = 1'b0;
	localparam logic RegHeight = 1'b1;

	typedef enum logic [1:0] {
		OP_NONE = 2'd0,
		OP_MOVE = 2'd1,
		OP_SEG  = 2'd2,
		OP_ERR  = 2'd3
	} op_t;

	typedef logic [CoordW-1:0] coord_t;

	typedef struct packed {
		logic                 clear;
		op_t                  op;
		logic [KindW-1:0]     cmd;
		logic                 rel;
		coord_t [MaxArgs-1:0] args;
	} entry_t;

	typedef struct packed {
		logic   is_error;
		coord_t start_x;
		coord_t start_y;
		coord_t ctrl1_x;
		coord_t ctrl1_y;
		coord_t ctrl2_x;
		coord_t ctrl2_y;
		coord_t end_x;
		coord_t end_y;
	} seg_t;

	function automatic logic [CntW-1:0] needed_args(input logic [KindW-1:0] cmd);
		logic [CntW-1:0] n;
		case (cmd)
			KindMove:   n = CntW'(2);
			KindCurve:  n = CntW'(6);
			KindSmooth: n = CntW'(4);
			KindLine:   n = CntW'(2);
			KindHoriz:  n = CntW'(1);
			KindVert:   n = CntW'(1);
			default:    n = CntW'(0);
		endcase
		return n;
	endfunction

endpackage

### hdl/pcbs_ifs.sv
// handshake interfaces for path tokens and bezier segments
interface pcbs_token_if;
	logic                           valid;
	logic                           ready;
	logic                           path_start;
	logic [pcbs_pkg::KindW-1:0]     token_kind;
	logic                           is_relative;
	logic signed [pcbs_pkg::CoordW-1:0] number_value;

	modport source (output valid, path_start, token_kind, is_relative, number_value,
		input ready);
	modport sink (input valid, path_start, token_kind, is_relative, number_value,
		output ready);
endinterface

interface pcbs_seg_if;
	logic                               valid;
	logic                               ready;
	logic                               is_error;
	logic signed [pcbs_pkg::CoordW-1:0] start_x;
	logic signed [pcbs_pkg::CoordW-1:0] start_y;
	logic signed [pcbs_pkg::CoordW-1:0] ctrl1_x;
	logic signed [pcbs_pkg::CoordW-1:0] ctrl1_y;
	logic signed [pcbs_pkg::CoordW-1:0] ctrl2_x;
	logic signed [pcbs_pkg::CoordW-1:0] ctrl2_y;
	logic signed [pcbs_pkg::CoordW-1:0] end_x;
	logic signed [pcbs_pkg::CoordW-1:0] end_y;

	modport source (output valid, is_error, start_x, start_y, ctrl1_x, ctrl1_y,
		ctrl2_x, ctrl2_y, end_x, end_y, input ready);
	modport sink (input valid, is_error, start_x, start_y, ctrl1_x, ctrl1_y,
		ctrl2_x, ctrl2_y, end_x, end_y, output ready);
endinterface

### hdl/pcbs_queue.sv
// small fifo of decoded operations between front and back
module pcbs_queue #(
	parameter int DEPTH = pcbs_pkg::QueueDepth
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  pcbs_pkg::entry_t push_data,
	output logic             full,
	input  logic             pop,
	output pcbs_pkg::entry_t pop_data,
	output logic             empty
);
	localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CntW = $clog2(DEPTH + 1);

	pcbs_pkg::entry_t mem_q [DEPTH];
	logic [PtrW-1:0]  wr_ptr_q;
	logic [PtrW-1:0]  rd_ptr_q;
	logic [CntW-1:0]  cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full     = (cnt_q == CntW'(DEPTH));
	assign empty    = (cnt_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end
endmodule

### hdl/pcbs_front.sv
// token front end: collects numbers, tracks the active command, flags errors
module pcbs_front (
	input  logic             clk,
	input  logic             arst_n,
	pcbs_token_if.sink       tok,
	input  logic             q_full,
	output logic             q_push,
	output pcbs_pkg::entry_t q_data
);
	localparam int CntW  = pcbs_pkg::CntW;
	localparam int KindW = pcbs_pkg::KindW;
	localparam int IdxW  = $clog2(pcbs_pkg::MaxArgs);

	pcbs_pkg::coord_t [pcbs_pkg::MaxArgs-1:0] pend_q;
	logic [CntW-1:0]  cnt_q, cnt_n, eff_cnt, new_cnt;
	logic [KindW-1:0] cmd_q, cmd_n, eff_cmd;
	logic             rel_q, rel_n, eff_rel;
	logic             failed_q, failed_n, eff_failed;
	logic             accept;
	logic             store;
	pcbs_pkg::op_t    op;

	assign tok.ready = !q_full;
	assign accept    = tok.valid && tok.ready;

	assign eff_cnt    = tok.path_start ? '0 : cnt_q;
	assign eff_cmd    = tok.path_start ? pcbs_pkg::KindNone : cmd_q;
	assign eff_rel    = tok.path_start ? 1'b0 : rel_q;
	assign eff_failed = tok.path_start ? 1'b0 : failed_q;

	always_comb begin
		cnt_n    = eff_cnt;
		cmd_n    = eff_cmd;
		rel_n    = eff_rel;
		failed_n = eff_failed;
		op       = pcbs_pkg::OP_NONE;
		store    = 1'b0;
		new_cnt  = (eff_cnt < CntW'(pcbs_pkg::MaxArgs)) ? eff_cnt + 1'b1 : eff_cnt;
		if (!eff_failed && tok.token_kind != pcbs_pkg::KindUnused) begin
			if (tok.token_kind != pcbs_pkg::KindNumber) begin
				if (eff_cnt != '0) begin
					failed_n = 1'b1;
					op       = pcbs_pkg::OP_ERR;
				end else begin
					cmd_n = tok.token_kind;
					rel_n = tok.is_relative;
				end
			end else begin
				store = (eff_cnt < CntW'(pcbs_pkg::MaxArgs));
				if (eff_cmd != pcbs_pkg::KindNone &&
						new_cnt == pcbs_pkg::needed_args(eff_cmd)) begin
					cnt_n = '0;
					op    = (eff_cmd == pcbs_pkg::KindMove) ? pcbs_pkg::OP_MOVE
						: pcbs_pkg::OP_SEG;
				end else begin
					cnt_n = new_cnt;
				end
			end
		end
	end

	always_comb begin
		q_data.clear = tok.path_start;
		q_data.op    = op;
		q_data.cmd   = eff_cmd;
		q_data.rel   = eff_rel;
		for (int i = 0; i < pcbs_pkg::MaxArgs; i++) begin
			q_data.args[i] = (eff_cnt == CntW'(i)) ? tok.number_value : pend_q[i];
		end
	end

	assign q_push = accept && (tok.path_start || op != pcbs_pkg::OP_NONE);

	always_ff @(posedge clk) begin
		if (accept && store) begin
			pend_q[eff_cnt[IdxW-1:0]] <= tok.number_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			cmd_q    <= pcbs_pkg::KindNone;
			rel_q    <= 1'b0;
			failed_q <= 1'b0;
		end else if (accept) begin
			cnt_q    <= cnt_n;
			cmd_q    <= cmd_n;
			rel_q    <= rel_n;
			failed_q <= failed_n;
		end
	end
endmodule

### hdl/pcbs_back.sv
// segment back end: current point, reflection, normalization and output register
module pcbs_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [pcbs_pkg::UnitsW-1:0] width_units,
	input  logic [pcbs_pkg::UnitsW-1:0] height_units,
	input  logic                        q_empty,
	input  pcbs_pkg::entry_t            q_data,
	output logic                        q_pop,
	pcbs_seg_if.source                  seg
);
	localparam int W = pcbs_pkg::CoordW;

	pcbs_pkg::coord_t pos_x_q, pos_y_q, prev_x_q, prev_y_q;
	logic             have_seg_q;
	pcbs_pkg::coord_t px, py, cx, cy;
	logic             have;
	pcbs_pkg::coord_t ox, oy;
	pcbs_pkg::coord_t a0x, a0y, a1x, a1y, a2x, a2y, vy;
	pcbs_pkg::coord_t p [8];
	pcbs_pkg::coord_t half_w, half_h;
	pcbs_pkg::seg_t   out_q, out_n;
	logic             out_valid_q;
	logic             can_take;

	assign can_take = !out_valid_q || seg.ready;
	assign q_pop    = !q_empty && can_take;

	assign px   = q_data.clear ? '0 : pos_x_q;
	assign py   = q_data.clear ? '0 : pos_y_q;
	assign cx   = q_data.clear ? '0 : prev_x_q;
	assign cy   = q_data.clear ? '0 : prev_y_q;
	assign have = q_data.clear ? 1'b0 : have_seg_q;

	assign ox  = q_data.rel ? px : '0;
	assign oy  = q_data.rel ? py : '0;
	assign a0x = ox + q_data.args[0];
	assign a0y = oy + q_data.args[1];
	assign a1x = ox + q_data.args[2];
	assign a1y = oy + q_data.args[3];
	assign a2x = ox + q_data.args[4];
	assign a2y = oy + q_data.args[5];
	assign vy  = oy + q_data.args[0];

	assign half_w = {{(W - pcbs_pkg::UnitsW + 1){1'b0}}, width_units[pcbs_pkg::UnitsW-1:1]};
	assign half_h = {{(W - pcbs_pkg::UnitsW + 1){1'b0}}, height_units[pcbs_pkg::UnitsW-1:1]};

	always_comb begin
		p[0] = px;
		p[1] = py;
		p[2] = px;
		p[3] = py;
		case (q_data.cmd)
			pcbs_pkg::KindCurve: begin
				p[2] = a0x; p[3] = a0y;
				p[4] = a1x; p[5] = a1y;
				p[6] = a2x; p[7] = a2y;
			end
			pcbs_pkg::KindSmooth: begin
				if (have) begin
					p[2] = {px[W-2:0], 1'b0} - cx;
					p[3] = {py[W-2:0], 1'b0} - cy;
				end
				p[4] = a0x; p[5] = a0y;
				p[6] = a1x; p[7] = a1y;
			end
			pcbs_pkg::KindLine: begin
				p[4] = a0x; p[5] = a0y;
				p[6] = a0x; p[7] = a0y;
			end
			pcbs_pkg::KindHoriz: begin
				p[4] = a0x; p[5] = py;
				p[6] = a0x; p[7] = py;
			end
			pcbs_pkg::KindVert: begin
				p[4] = px; p[5] = vy;
				p[6] = px; p[7] = vy;
			end
			default: begin
				p[4] = px; p[5] = py;
				p[6] = px; p[7] = py;
			end
		endcase
	end

	always_comb begin
		out_n          = '0;
		out_n.is_error = 1'b1;
		if (q_data.op == pcbs_pkg::OP_SEG) begin
			out_n.is_error = 1'b0;
			out_n.start_x  = pcbs_pkg::coord_t'($signed(p[0]) >>> 5) - half_w;
			out_n.start_y  = half_h - pcbs_pkg::coord_t'($signed(p[1]) >>> 5);
			out_n.ctrl1_x  = pcbs_pkg::coord_t'($signed(p[2]) >>> 5) - half_w;
			out_n.ctrl1_y  = half_h - pcbs_pkg::coord_t'($signed(p[3]) >>> 5);
			out_n.ctrl2_x  = pcbs_pkg::coord_t'($signed(p[4]) >>> 5) - half_w;
			out_n.ctrl2_y  = half_h - pcbs_pkg::coord_t'($signed(p[5]) >>> 5);
			out_n.end_x    = pcbs_pkg::coord_t'($signed(p[6]) >>> 5) - half_w;
			out_n.end_y    = half_h - pcbs_pkg::coord_t'($signed(p[7]) >>> 5);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q     <= '0;
			pos_y_q     <= '0;
			prev_x_q    <= '0;
			prev_y_q    <= '0;
			have_seg_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				out_valid_q <= (q_data.op == pcbs_pkg::OP_SEG) ||
					(q_data.op == pcbs_pkg::OP_ERR);
			end else if (seg.ready) begin
				out_valid_q <= 1'b0;
			end
			if (q_pop) begin
				case (q_data.op)
					pcbs_pkg::OP_MOVE: begin
						pos_x_q    <= a0x;
						pos_y_q    <= a0y;
						prev_x_q   <= cx;
						prev_y_q   <= cy;
						have_seg_q <= have;
					end
					pcbs_pkg::OP_SEG: begin
						pos_x_q    <= p[6];
						pos_y_q    <= p[7];
						prev_x_q   <= p[4];
						prev_y_q   <= p[5];
						have_seg_q <= 1'b1;
					end
					default: begin
						pos_x_q    <= px;
						pos_y_q    <= py;
						prev_x_q   <= cx;
						prev_y_q   <= cy;
						have_seg_q <= have;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			out_q <= out_n;
		end
	end

	assign seg.valid    = out_valid_q;
	assign seg.is_error = out_q.is_error;
	assign seg.start_x  = out_q.start_x;
	assign seg.start_y  = out_q.start_y;
	assign seg.ctrl1_x  = out_q.ctrl1_x;
	assign seg.ctrl1_y  = out_q.ctrl1_y;
	assign seg.ctrl2_x  = out_q.ctrl2_x;
	assign seg.ctrl2_y  = out_q.ctrl2_y;
	assign seg.end_x    = out_q.end_x;
	assign seg.end_y    = out_q.end_y;
endmodule

### hdl/path_command_to_bezier_segments_top.sv
// top level: path tokens in, normalized cubic segments out
// one token accepted per cycle while the operation queue has room
// a segment or error item passes from its token through the queue, then the output register
// back end retires one queued operation per cycle while its output register can take it
// arst_n clears the path state, the queue and the output valid flag; widths reset to zero
// no clearing pass: the pending number store is only read where it was written
module path_command_to_bezier_segments_top #(
	parameter int QUEUE_DEPTH = pcbs_pkg::QueueDepth
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic                        cfg_index,
	input  logic [pcbs_pkg::UnitsW-1:0] cfg_data,
	pcbs_token_if.sink                  tok,
	pcbs_seg_if.source                  seg
);
	logic [pcbs_pkg::UnitsW-1:0] width_q, height_q;
	logic             q_push, q_full, q_pop, q_empty;
	pcbs_pkg::entry_t q_in, q_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= '0;
			height_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				pcbs_pkg::RegWidth:  width_q  <= cfg_data;
				pcbs_pkg::RegHeight: height_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	pcbs_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.tok    (tok),
		.q_full (q_full),
		.q_push (q_push),
		.q_data (q_in)
	);

	pcbs_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_in),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (q_out),
		.empty     (q_empty)
	);

	pcbs_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.width_units  (width_q),
		.height_units (height_q),
		.q_empty      (q_empty),
		.q_data       (q_out),
		.q_pop        (q_pop),
		.seg          (seg)
	);
endmodule
